// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file, nanc_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nanc_pkg.sv =====
// Shared constants and types of the NLMS noise canceller.
// No dependencies; imported by nanc_dp, nanc_ctrl and the top level.
`default_nettype none
package nanc_pkg;

  localparam int TAPS_DEF  = 32;
  localparam int DELAY_DEF = 1;

  // config register indexes
  localparam logic [1:0] REG_STEP  = 2'd0;
  localparam logic [1:0] REG_LEAK  = 2'd1;
  localparam logic [1:0] REG_FLOOR = 2'd2;

  localparam logic [15:0] STEP_RST  = 16'd1638;
  localparam logic [15:0] LEAK_RST  = 16'd32768;
  localparam logic [31:0] FLOOR_RST = 32'd1024;

  // 0.01 in Q2.21
  localparam logic [15:0] GRAD_CLIP = 16'd20972;
  localparam int          QUOT_W    = 41;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic upd;
    logic eval;
    logic div_init;
    logic div_chk;
    logic div_step;
    logic step_fix;
    logic fin;
  } nanc_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/nanc_dp.sv =====
// Datapath: history and weight memories, MAC/update pipeline, divider.
// Depends on nanc_pkg; driven by nanc_ctrl commands.
`default_nettype none
module nanc_dp
  import nanc_pkg::*;
#(
  parameter int TAPS  = TAPS_DEF,
  parameter int DELAY = DELAY_DEF,
  localparam int HLEN = TAPS + DELAY,
  localparam int HAW  = (HLEN > 1) ? $clog2(HLEN) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire nanc_cmd_t       cmd,
  input  wire logic [HAW-1:0]  idx,
  input  wire logic [15:0]     sample,
  input  wire logic [15:0]     step_size,
  input  wire logic [15:0]     leak_factor,
  input  wire logic [31:0]     energy_floor,
  output logic [15:0]          residual
);

  localparam int TAW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W  = 40 + $clog2(TAPS);
  localparam int NORM_W = 34 + $clog2(TAPS);
  localparam int DW     = NORM_W + QUOT_W;
  localparam logic signed [ACC_W:0] PRED_RND = (ACC_W+1)'(1) << 20;
  localparam logic [QUOT_W-1:0] STEP_CAP = QUOT_W'(1) << 40;

  logic signed [15:0] hist_mem [HLEN];
  logic signed [23:0] w_mem [TAPS];

  logic [HAW-1:0] head_r;
  logic signed [15:0] sample_r, e_r, hx_q, out_r;
  logic signed [23:0] w_q;
  logic v1_r, upd1_r, v2_r, upd2_r, neg2_r;
  logic [TAW-1:0] k1_r, k2_r;
  logic signed [39:0] pwx_r;
  logic [30:0] pxx_r;
  logic [56:0] pg_r;
  logic signed [40:0] pl_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [NORM_W-1:0] norm_r;
  logic [DW-1:0] rem_r, dvs_r;
  logic [QUOT_W-1:0] q_r, step_r;
  logic ovf_r, zero_r;

  // history address of tap idx: head - DELAY - idx, wrapped
  logic signed [HAW+1:0] hdiff, hwrap;
  logic [HAW-1:0] haddr, head_nxt;
  always_comb begin
    hdiff = $signed({2'b00, head_r}) - $signed((HAW+2)'(DELAY)) - $signed({2'b00, idx});
    hwrap = (hdiff < 0) ? hdiff + $signed((HAW+2)'(HLEN)) : hdiff;
    haddr = hwrap[HAW-1:0];
    head_nxt = (head_r == HAW'(HLEN-1)) ? '0 : head_r + 1'b1;
  end

  // history memory
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      hist_mem[idx] <= '0;
    end else if (cmd.fin) begin
      hist_mem[head_nxt] <= sample_r;
    end
    if (cmd.rd) begin
      hx_q <= hist_mem[haddr];
    end
  end

  // weight update arithmetic (stage 3)
  logic signed [41:0] lsum;
  logic signed [26:0] wl;
  logic [32:0] gabs;
  logic [15:0] gclip;
  logic signed [27:0] wn;
  logic signed [23:0] wsat;
  always_comb begin
    lsum  = {pl_r[40], pl_r} + 42'sd16384;
    wl    = lsum[41:15];
    gabs  = pg_r[56:24];
    gclip = (gabs > 33'(GRAD_CLIP)) ? GRAD_CLIP : gabs[15:0];
    wn    = 28'(wl) + (neg2_r ? -$signed({12'd0, gclip}) : $signed({12'd0, gclip}));
    if (wn > 28'sd8388607) begin
      wsat = 24'sh7FFFFF;
    end else if (wn < -28'sd8388608) begin
      wsat = -24'sh800000;
    end else begin
      wsat = wn[23:0];
    end
  end

  // weight memory: one write port (clear or update), one read port
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      if (32'(idx) < TAPS) begin
        w_mem[idx[TAW-1:0]] <= '0;
      end
    end else if (v2_r && upd2_r) begin
      w_mem[k2_r] <= wsat;
    end
    if (cmd.rd) begin
      w_q <= w_mem[idx[TAW-1:0]];
    end
  end

  logic [15:0] xmag, emag;
  logic signed [31:0] xsq;
  always_comb begin
    xmag = hx_q[15] ? 16'(-hx_q) : hx_q;
    emag = e_r[15] ? 16'(-e_r) : e_r;
    xsq  = hx_q * hx_q;
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      head_r <= '0;
    end else begin
      v1_r <= cmd.rd;
      v2_r <= v1_r;
      if (cmd.fin) begin
        head_r <= head_nxt;
      end
    end
  end

  // prediction error
  logic signed [ACC_W:0] asum;
  logic signed [ACC_W-21:0] pred;
  logic signed [ACC_W-19:0] diff;
  logic signed [15:0] esat;
  always_comb begin
    asum = {acc_r[ACC_W-1], acc_r} + PRED_RND;
    pred = asum[ACC_W:21];
    diff = (ACC_W-18)'(sample_r) - (ACC_W-18)'(pred);
    if (diff > 32767) begin
      esat = 16'sh7FFF;
    end else if (diff < -32768) begin
      esat = -16'sh8000;
    end else begin
      esat = diff[15:0];
    end
  end

  logic [31:0] mprod;
  assign mprod = step_size * emag;

  always_ff @(posedge clk) begin
    upd1_r <= cmd.upd;
    k1_r   <= idx[TAW-1:0];
    upd2_r <= upd1_r;
    k2_r   <= k1_r;
    neg2_r <= e_r[15] ^ hx_q[15];
    pwx_r  <= w_q * hx_q;
    pxx_r  <= xsq[30:0];
    pg_r   <= step_r * xmag;
    pl_r   <= $signed({1'b0, leak_factor}) * w_q;

    if (cmd.load) begin
      sample_r <= sample;
      acc_r    <= '0;
      norm_r   <= NORM_W'(energy_floor);
    end else if (v2_r && !upd2_r) begin
      acc_r  <= acc_r + ACC_W'(pwx_r);
      norm_r <= norm_r + NORM_W'(pxx_r);
    end

    if (cmd.eval) begin
      e_r <= esat;
    end
    if (cmd.div_init) begin
      rem_r  <= DW'({mprod, 31'd0});
      dvs_r  <= DW'(norm_r) << 40;
      zero_r <= (norm_r == '0);
    end else if (cmd.div_step) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rem_r - dvs_r;
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.div_chk) begin
      // quotient at or above 2^41 lands on the cap anyway
      ovf_r <= (rem_r >= (dvs_r << 1));
      q_r   <= '0;
    end else if (cmd.div_step) begin
      q_r <= {q_r[QUOT_W-2:0], (rem_r >= dvs_r)};
    end
    if (cmd.step_fix) begin
      if (zero_r) begin
        step_r <= '0;
      end else if (ovf_r || q_r > STEP_CAP) begin
        step_r <= STEP_CAP;
      end else begin
        step_r <= q_r;
      end
    end
    if (cmd.fin) begin
      out_r <= e_r;
    end
  end

  assign residual = out_r;

endmodule
`default_nettype wire

// ===== rtl/nanc_ctrl.sv =====
// Sequencer: clearing pass, MAC pass, divide, update pass, result hand-off.
// Depends on nanc_pkg; issues commands to nanc_dp.
`default_nettype none
module nanc_ctrl
  import nanc_pkg::*;
#(
  parameter int TAPS  = TAPS_DEF,
  parameter int DELAY = DELAY_DEF,
  localparam int HLEN = TAPS + DELAY,
  localparam int HAW  = (HLEN > 1) ? $clog2(HLEN) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output nanc_cmd_t           cmd,
  output logic [HAW-1:0]      idx
);

  localparam int CW = (HAW > 6) ? HAW : 6;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_MAC  = 4'd2;
  localparam logic [3:0] ST_MDRN = 4'd3;
  localparam logic [3:0] ST_EVAL = 4'd4;
  localparam logic [3:0] ST_DINI = 4'd5;
  localparam logic [3:0] ST_DCHK = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_SFIX = 4'd8;
  localparam logic [3:0] ST_UPD  = 4'd9;
  localparam logic [3:0] ST_UDRN = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(HLEN-1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MAC;
          cnt_nxt   = '0;
        end
      end
      ST_MAC, ST_UPD: begin
        cmd.rd  = 1'b1;
        cmd.upd = (state_r == ST_UPD);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(TAPS-1)) begin
          state_nxt = (state_r == ST_MAC) ? ST_MDRN : ST_UDRN;
          cnt_nxt   = '0;
        end
      end
      // drain: wait for the read and product stages to empty
      ST_MDRN, ST_UDRN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = (state_r == ST_MDRN) ? ST_EVAL : ST_FIN;
          cnt_nxt   = '0;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_DINI;
      end
      ST_DINI: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DCHK;
      end
      ST_DCHK: begin
        cmd.div_chk = 1'b1;
        state_nxt   = ST_DIV;
        cnt_nxt     = '0;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(QUOT_W-1)) begin
          state_nxt = ST_SFIX;
          cnt_nxt   = '0;
        end
      end
      ST_SFIX: begin
        cmd.step_fix = 1'b1;
        state_nxt    = ST_UPD;
        cnt_nxt      = '0;
      end
      ST_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.fin   = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign idx       = cnt_r[HAW-1:0];

endmodule
`default_nettype wire

// ===== rtl/nlms_adaptive_noise_canceller.sv =====
// NLMS adaptive noise canceller: one sample in, one Q1.15 residual out per
// transfer. After reset a clearing pass zeroes the history and the weights;
// no sample is taken meanwhile. Each sample then goes through a MAC pass
// over the taps, a restoring divide for the normalized step, and an update
// pass, all through history and weight memories with one write port and
// one read port each. A finished residual sits in an output register, so
// the next sample is taken while it waits.
// Depends on nanc_pkg, nanc_ctrl and nanc_dp.
`default_nettype none
module nlms_adaptive_noise_canceller
  import nanc_pkg::*;
#(
  parameter int TAPS  = TAPS_DEF,
  parameter int DELAY = DELAY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // [15:0] sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // [15:0] residual
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int HLEN = TAPS + DELAY;
  localparam int HAW  = (HLEN > 1) ? $clog2(HLEN) : 1;

  logic [15:0] step_r, leak_r;
  logic [31:0] floor_r;
  logic [1:0] ridx;
  logic wr;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[3:2];
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RST;
      leak_r  <= LEAK_RST;
      floor_r <= FLOOR_RST;
    end else if (wr) begin
      case (ridx)
        REG_STEP:  step_r  <= cfg_pwdata[15:0];
        REG_LEAK:  leak_r  <= cfg_pwdata[15:0];
        REG_FLOOR: floor_r <= cfg_pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_STEP:  cfg_prdata = {16'd0, step_r};
      REG_LEAK:  cfg_prdata = {16'd0, leak_r};
      REG_FLOOR: cfg_prdata = floor_r;
      default:   cfg_prdata = '0;
    endcase
  end

  nanc_cmd_t cmd;
  logic [HAW-1:0] idx;

  nanc_ctrl #(.TAPS(TAPS), .DELAY(DELAY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .idx       (idx)
  );

  nanc_dp #(.TAPS(TAPS), .DELAY(DELAY)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .idx          (idx),
    .sample       (in_tdata),
    .step_size    (step_r),
    .leak_factor  (leak_r),
    .energy_floor (floor_r),
    .residual     (out_tdata)
  );

endmodule
`default_nettype wire

// ===== rtl/nanc_checker.sv =====
// Port-level checks for the NLMS noise canceller, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module nanc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        cfg_psel,
  input wire logic        cfg_pready
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "second sample taken before the first finished")
  `ASSERT_IMPL(a_pready, clk, rst_n, cfg_psel, cfg_pready, "config port not ready")

endmodule

bind nlms_adaptive_noise_canceller nanc_checker u_nanc_checker (.*);
`default_nettype wire
